FILE: rtl/centered_line_rasterizer_defines.svh
// Assertion macros for the centered line rasteriser.
// Included by the top level; no other dependencies.
`ifndef CENTERED_LINE_RASTERIZER_DEFINES_SVH
`define CENTERED_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("clr: assertion failed");

// Next-cycle implication, disabled during reset.
`define CLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("clr: assertion failed");

`endif

FILE: rtl/clr_pkg.sv
// Shared constants, types and codes for the centered line rasteriser.
// No dependencies; used by every module of the block.
`default_nettype none

package clr_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_BITS   = 13;
  localparam int COLOR_BITS = 24;
  localparam int ADDR_BITS  = 24;
  localparam int SCR_BITS   = 13;
  localparam int ERR_BITS   = COORD_BITS + 2;
  // screen coordinate before truncation
  localparam int XW         = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;

  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_BITS  = 2 * SCR_BITS + ADDR_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FLD_BITS + 7) / 8) * 8;

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam logic [CFG_BITS-1:0] WIDTH_RST  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] HEIGHT_RST = CFG_BITS'(480);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic                         last;
  } pix_t;

  typedef struct packed {
    logic [SCR_BITS-1:0]   scr_x;
    logic [SCR_BITS-1:0]   scr_y;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] color;
    logic                  off;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 full;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/clr_front.sv
// Front end: takes load/advance requests and runs the Bresenham stepper.
// Depends on clr_pkg.
`default_nettype none

module clr_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 acc_i,
  input  wire clr_pkg::op_e                         op_i,
  input  wire logic signed [clr_pkg::COORD_BITS-1:0] start_x_i,
  input  wire logic signed [clr_pkg::COORD_BITS-1:0] start_y_i,
  input  wire logic signed [clr_pkg::COORD_BITS-1:0] end_x_i,
  input  wire logic signed [clr_pkg::COORD_BITS-1:0] end_y_i,
  input  wire logic [clr_pkg::COLOR_BITS-1:0]       color_i,
  output logic                                      push_o,
  output clr_pkg::pix_t                             pix_o
);

  localparam int CB = clr_pkg::COORD_BITS;
  localparam int EB = clr_pkg::ERR_BITS;

  logic signed [CB-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic [CB-1:0] dx_q, dy_q;
  logic [1:0] dirs_q;
  logic signed [EB-1:0] err_q;
  logic [clr_pkg::COLOR_BITS-1:0] color_q;
  logic active_q;

  // load path
  logic signed [CB:0] ld_dfx, ld_dfy, ld_nfx, ld_nfy;
  logic [CB-1:0] ld_dx, ld_dy;
  logic [1:0] ld_dirs;
  logic signed [EB-1:0] ld_err;
  logic ld_last;

  // advance path
  logic signed [EB:0] twice, neg_dy, pos_dx;
  logic step_x, step_y;
  logic signed [EB-1:0] adv_err;
  logic signed [CB-1:0] adv_x, adv_y;
  logic adv_last;

  always_comb begin
    ld_dfx  = $signed({end_x_i[CB-1], end_x_i}) - $signed({start_x_i[CB-1], start_x_i});
    ld_dfy  = $signed({end_y_i[CB-1], end_y_i}) - $signed({start_y_i[CB-1], start_y_i});
    ld_nfx  = -ld_dfx;
    ld_nfy  = -ld_dfy;
    ld_dx   = ld_dfx[CB] ? ld_nfx[CB-1:0] : ld_dfx[CB-1:0];
    ld_dy   = ld_dfy[CB] ? ld_nfy[CB-1:0] : ld_dfy[CB-1:0];
    ld_dirs = {!(start_y_i < end_y_i), !(start_x_i < end_x_i)};
    ld_err  = $signed({2'b00, ld_dx}) - $signed({2'b00, ld_dy});
    ld_last = (start_x_i == end_x_i) && (start_y_i == end_y_i);
  end

  always_comb begin
    twice   = {err_q, 1'b0};
    neg_dy  = -$signed({3'b000, dy_q});
    pos_dx  = $signed({3'b000, dx_q});
    step_x  = twice > neg_dy;
    step_y  = twice < pos_dx;
    adv_err = err_q - (step_x ? $signed({2'b00, dy_q}) : '0)
                    + (step_y ? $signed({2'b00, dx_q}) : '0);
    adv_x   = cur_x_q;
    adv_y   = cur_y_q;
    if (step_x) begin
      adv_x = dirs_q[0] ? cur_x_q - CB'(1) : cur_x_q + CB'(1);
    end
    if (step_y) begin
      adv_y = dirs_q[1] ? cur_y_q - CB'(1) : cur_y_q + CB'(1);
    end
    adv_last = (adv_x == tgt_x_q) && (adv_y == tgt_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (acc_i) begin
      if (op_i == clr_pkg::OP_LOAD) begin
        active_q <= !ld_last;
      end else if (active_q) begin
        active_q <= !adv_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      if (op_i == clr_pkg::OP_LOAD) begin
        cur_x_q <= start_x_i;
        cur_y_q <= start_y_i;
        tgt_x_q <= end_x_i;
        tgt_y_q <= end_y_i;
        dx_q    <= ld_dx;
        dy_q    <= ld_dy;
        dirs_q  <= ld_dirs;
        err_q   <= ld_err;
        color_q <= color_i;
      end else if (active_q) begin
        cur_x_q <= adv_x;
        cur_y_q <= adv_y;
        err_q   <= adv_err;
      end
    end
  end

  always_comb begin
    push_o = acc_i && ((op_i == clr_pkg::OP_LOAD) || active_q);
    if (op_i == clr_pkg::OP_LOAD) begin
      pix_o = '{x: start_x_i, y: start_y_i, color: color_i, last: ld_last};
    end else begin
      pix_o = '{x: adv_x, y: adv_y, color: color_q, last: adv_last};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clr_queue.sv
// Short pixel queue between the stepper and the screen mapper.
// Depends on clr_pkg.
`default_nettype none

module clr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire clr_pkg::pix_t  data_i,
  input  wire logic           pop_i,
  output clr_pkg::pix_t       data_o,
  output logic                valid_o,
  output clr_pkg::q_stat_t    stat_o
);

  localparam int PB = clr_pkg::QPTR_BITS;
  localparam int NB = clr_pkg::QCNT_BITS;

  clr_pkg::pix_t mem_q [clr_pkg::QDEPTH];
  logic [PB-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NB-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign do_push = push_i && (cnt_q != NB'(clr_pkg::QDEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign stat_o  = '{count: cnt_q, full: cnt_q == NB'(clr_pkg::QDEPTH)};

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PB'(clr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PB'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PB'(clr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PB'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NB'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clr_back.sv
// Back end: maps centred pixels to screen space, bounds check, address.
// Two registered stages; depends on clr_pkg.
`default_nettype none

module clr_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             q_valid_i,
  input  wire clr_pkg::pix_t                    q_data_i,
  output logic                                  pop_o,
  input  wire logic [clr_pkg::CFG_BITS-1:0]     width_i,
  input  wire logic [clr_pkg::CFG_BITS-1:0]     height_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output clr_pkg::out_t                         out_o
);

  localparam int CB = clr_pkg::COORD_BITS;
  localparam int WB = clr_pkg::CFG_BITS;
  localparam int XW = clr_pkg::XW;

  logic v1_q, v2_q;
  logic s1_ready, s2_ready;

  logic signed [XW-1:0] sx1_q, sy1_q;
  logic off1_q, last1_q;
  logic [clr_pkg::COLOR_BITS-1:0] color1_q;
  clr_pkg::out_t out_q;

  logic signed [XW-1:0] half_w, half_h, cx, cy, sx_c, sy_c, w_s, h_s;
  logic off_c;
  logic [2*WB-1:0] prod, sum;

  assign s2_ready    = !v2_q || out_ready_i;
  assign s1_ready    = !v1_q || s2_ready;
  assign pop_o       = q_valid_i && s1_ready;
  assign out_valid_o = v2_q;
  assign out_o       = out_q;

  always_comb begin
    half_w = $signed({{(XW-WB+1){1'b0}}, width_i[WB-1:1]});
    half_h = $signed({{(XW-WB+1){1'b0}}, height_i[WB-1:1]});
    w_s    = $signed({{(XW-WB){1'b0}}, width_i});
    h_s    = $signed({{(XW-WB){1'b0}}, height_i});
    cx     = $signed({{(XW-CB){q_data_i.x[CB-1]}}, q_data_i.x});
    cy     = $signed({{(XW-CB){q_data_i.y[CB-1]}}, q_data_i.y});
    sx_c   = cx + half_w;
    sy_c   = half_h - cy;
    off_c  = sx_c[XW-1] || (sx_c >= w_s) || sy_c[XW-1] || (sy_c >= h_s);
  end

  // row index is below the height when on screen, so its low bits suffice
  always_comb begin
    prod = sy1_q[WB-1:0] * width_i;
    sum  = prod + {{WB{1'b0}}, sx1_q[WB-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_q <= q_valid_i;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sx1_q    <= sx_c;
      sy1_q    <= sy_c;
      off1_q   <= off_c;
      color1_q <= q_data_i.color;
      last1_q  <= q_data_i.last;
    end
    if (s2_ready && v1_q) begin
      out_q.scr_x <= sx1_q[clr_pkg::SCR_BITS-1:0];
      out_q.scr_y <= sy1_q[clr_pkg::SCR_BITS-1:0];
      out_q.addr  <= off1_q ? '0 : sum[clr_pkg::ADDR_BITS-1:0];
      out_q.color <= color1_q;
      out_q.off   <= off1_q;
      out_q.last  <= last1_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/centered_line_rasterizer.sv
// Channel   Dir  Payload
// s_axis    in   tuser operation; tdata start_x, start_y, end_x, end_y, color
// m_axis    out  tuser off_screen; tlast last_pixel; tdata screen_x/y, address, colour
// apb       in   screen_width at 0x0, screen_height at 0x4
//
// One request per cycle while the queue has room; the stepper state is registered.
// A pixel passes through the queue, the map stage and the address stage to m_axis.
// The two-entry queue lets input keep flowing while m_axis is stalled, until it fills.
// Reset clears the line and queue; registers return to 640 x 480.
// Top level of the centred line rasteriser; depends on clr_pkg, clr_front,
// clr_queue, clr_back and centered_line_rasterizer_defines.svh.
`default_nettype none
`include "centered_line_rasterizer_defines.svh"

module centered_line_rasterizer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // start_x, start_y, end_x, end_y, color (lowest first)
  input  wire logic [clr_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // operation
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // screen_x, screen_y, pixel_address, pixel_color, zero pad (lowest first)
  output logic [clr_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,
  // off_screen
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tlast,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [clr_pkg::PADDR_BITS-1:0]      paddr,
  input  wire logic [clr_pkg::PDATA_BITS-1:0]      pwdata,
  output logic [clr_pkg::PDATA_BITS-1:0]           prdata,
  output logic                                     pready
);

  localparam int CB = clr_pkg::COORD_BITS;
  localparam int WB = clr_pkg::CFG_BITS;
  localparam int CL = clr_pkg::COLOR_BITS;

  logic [WB-1:0] width_q, height_q;
  clr_pkg::reg_idx_e reg_idx;
  logic cfg_wr;

  logic acc;
  logic push, pop, q_valid;
  clr_pkg::pix_t push_pix, q_pix;
  clr_pkg::q_stat_t q_stat;
  clr_pkg::out_t out_s;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = clr_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      clr_pkg::REG_WIDTH:  prdata = {{(clr_pkg::PDATA_BITS-WB){1'b0}}, width_q};
      clr_pkg::REG_HEIGHT: prdata = {{(clr_pkg::PDATA_BITS-WB){1'b0}}, height_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clr_pkg::WIDTH_RST;
      height_q <= clr_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      if (reg_idx == clr_pkg::REG_WIDTH) begin
        width_q <= pwdata[WB-1:0];
      end else begin
        height_q <= pwdata[WB-1:0];
      end
    end
  end

  assign s_axis_tready = !q_stat.full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  clr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .op_i      (clr_pkg::op_e'(s_axis_tuser)),
    .start_x_i ($signed(s_axis_tdata[CB-1:0])),
    .start_y_i ($signed(s_axis_tdata[2*CB-1:CB])),
    .end_x_i   ($signed(s_axis_tdata[3*CB-1:2*CB])),
    .end_y_i   ($signed(s_axis_tdata[4*CB-1:3*CB])),
    .color_i   (s_axis_tdata[4*CB+CL-1:4*CB]),
    .push_o    (push),
    .pix_o     (push_pix)
  );

  clr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_pix),
    .pop_i   (pop),
    .data_o  (q_pix),
    .valid_o (q_valid),
    .stat_o  (q_stat)
  );

  clr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_pix),
    .pop_o       (pop),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_s)
  );

  assign m_axis_tdata = {{(clr_pkg::OUT_DATA_BITS-clr_pkg::OUT_FLD_BITS){1'b0}},
                         out_s.color, out_s.addr, out_s.scr_y, out_s.scr_x};
  assign m_axis_tuser = out_s.off;
  assign m_axis_tlast = out_s.last;

  `CLR_ASSERT_IMPL(a_off_addr_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, out_s.addr == '0)
  `CLR_ASSERT_IMPL(a_q_bound, clk_i, rst_ni, 1'b1, q_stat.count <= clr_pkg::QCNT_BITS'(clr_pkg::QDEPTH))
  `CLR_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, q_stat.full && !pop, q_stat.full)

endmodule

`default_nettype wire

FILE: tb/sv/tb_centered_line_rasterizer.sv
// Self-checking bench for centered_line_rasterizer: line loads and advances on the
// input stream, screen sizes over APB, every pixel checked against a Bresenham model or a table.
// Depends on clr_pkg and the centered_line_rasterizer RTL.
module tb_centered_line_rasterizer;
  import clr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int N_DIR = 25;
  localparam int N_PHASE = 9;
  localparam int PHASE_PIXELS = 150;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    op_e                   op;
    coord_t                sx, sy, ex, ey;
    logic [COLOR_BITS-1:0] col;
    bit                    typed;
    out_t                  want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;  // start_x, start_y, end_x, end_y, color
  logic s_axis_tuser = 1'b0;                    // operation
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;       // screen_x, screen_y, pixel_address, colour
  logic m_axis_tuser;                           // off_screen
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic pready;

  centered_line_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [CFG_BITS-1:0] scr_w = WIDTH_RST;
  logic [CFG_BITS-1:0] scr_h = HEIGHT_RST;
  coord_t pen_x = '0, pen_y = '0, goal_x = '0, goal_y = '0;
  logic [COORD_BITS-1:0] span_x = '0, span_y = '0;
  logic [1:0] dir_neg = '0;
  logic signed [ERR_BITS-1:0] err_acc = '0;
  logic [COLOR_BITS-1:0] ink = '0;
  bit drawing = 1'b0;

  out_t pixel_q[$];
  int mismatches = 0;
  int n_pixels = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  stim_row_t dir_tab [N_DIR] = '{
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_LOAD, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'hFFFFFF, 1'b1,
      out_t'{13'd320, 13'd240, 24'd153920, 24'hFFFFFF, 1'b0, 1'b1}},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_LOAD, -12'sd320, 12'sd240, -12'sd317, 12'sd240, 24'h0, 1'b1,
      out_t'{13'd0, 13'd0, 24'd0, 24'h0, 1'b0, 1'b0}},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_LOAD, 12'sd319, -12'sd239, 12'sd319, -12'sd239, 24'h123456, 1'b1,
      out_t'{13'd639, 13'd479, 24'd307199, 24'h123456, 1'b0, 1'b1}},
    '{OP_LOAD, 12'sd320, 12'sd0, 12'sd318, -12'sd5, 24'hABCDEF, 1'b1,
      out_t'{13'd640, 13'd240, 24'd0, 24'hABCDEF, 1'b1, 1'b0}},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_LOAD, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048, 24'h00FF00, 1'b1,
      out_t'{13'd2367, 13'd6385, 24'd0, 24'h00FF00, 1'b1, 1'b0}},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    // new line while the previous one is still running
    '{OP_LOAD, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 24'hFF0000, 1'b1,
      out_t'{13'd6464, 13'd2288, 24'd0, 24'hFF0000, 1'b1, 1'b0}},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_LOAD, 12'sd5, 12'sd5, -12'sd5, 12'sd5, 24'h000001, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_LOAD, 12'sd0, 12'sd0, 12'sd3, -12'sd1, 24'hFEDCBA, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0},
    '{OP_ADVANCE, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 24'h0, 1'b0, '0}
  };

  logic [CFG_BITS-1:0] phase_w [N_PHASE] = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4096,
                                             13'd1, 13'd0, 13'd0, 13'd640};
  logic [CFG_BITS-1:0] phase_h [N_PHASE] = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd1,
                                             13'd4096, 13'd300, 13'd0, 13'd480};

  function automatic out_t map_pixel(bit last);
    longint cx, cy;
    out_t px;
    cx = longint'(pen_x) + longint'(scr_w / 2);
    cy = longint'(scr_h / 2) - longint'(pen_y);
    px.scr_x = SCR_BITS'(cx);
    px.scr_y = SCR_BITS'(cy);
    px.off = cx < 0 || cx >= longint'(scr_w) || cy < 0 || cy >= longint'(scr_h);
    px.addr = px.off ? '0 : ADDR_BITS'(cy * longint'(scr_w) + cx);
    px.color = ink;
    px.last = last;
    return px;
  endfunction

  function automatic bit trace_pixel(op_e op, logic [IN_DATA_BITS-1:0] d, output out_t px);
    int twice;
    bit last;
    if (op == OP_LOAD) begin
      pen_x = d[0 +: CB];
      pen_y = d[CB +: CB];
      goal_x = d[2*CB +: CB];
      goal_y = d[3*CB +: CB];
      ink = d[4*CB +: COLOR_BITS];
      span_x = (goal_x > pen_x) ? goal_x - pen_x : pen_x - goal_x;
      span_y = (goal_y > pen_y) ? goal_y - pen_y : pen_y - goal_y;
      dir_neg = {pen_y >= goal_y, pen_x >= goal_x};
      err_acc = ERR_BITS'(int'(span_x) - int'(span_y));
      last = (pen_x == goal_x) && (pen_y == goal_y);
      drawing = !last;
    end else begin
      if (!drawing) return 1'b0;
      twice = 2 * int'(err_acc);
      if (twice > -int'(span_y)) begin
        err_acc = ERR_BITS'(int'(err_acc) - int'(span_y));
        pen_x = dir_neg[0] ? pen_x - 1 : pen_x + 1;
      end
      if (twice < int'(span_x)) begin
        err_acc = ERR_BITS'(int'(err_acc) + int'(span_x));
        pen_y = dir_neg[1] ? pen_y - 1 : pen_y + 1;
      end
      last = (pen_x == goal_x) && (pen_y == goal_y);
      if (last) drawing = 1'b0;
    end
    px = map_pixel(last);
    return 1'b1;
  endfunction

  function automatic logic [IN_DATA_BITS-1:0] pack_line(coord_t sx, sy, ex, ey,
                                                       logic [COLOR_BITS-1:0] col);
    return IN_DATA_BITS'({col, ey, ex, sy, sx});
  endfunction

  function automatic coord_t clampc(int v);
    if (v < -(1 << (CB - 1))) return coord_t'(-(1 << (CB - 1)));
    if (v > (1 << (CB - 1)) - 1) return coord_t'((1 << (CB - 1)) - 1);
    return coord_t'(v);
  endfunction

  // centred coordinate around the visible area, a little past each border
  function automatic coord_t near(logic [CFG_BITS-1:0] span);
    int half;
    half = int'(span) / 2 + 2;
    return clampc(int'($urandom_range(2 * half)) - half);
  endfunction

  function automatic string fmt_pixel(out_t p);
    return $sformatf("x %0d y %0d addr 0x%06h col 0x%06h off %0b last %0b",
                     $signed(p.scr_x), $signed(p.scr_y), p.addr, p.color, p.off, p.last);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic offer(op_e op, logic [IN_DATA_BITS-1:0] d, bit typed, out_t want);
    out_t px;
    while (!steady && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (trace_pixel(op, d, px)) begin
      pixel_q.push_back(typed ? want : px);
      n_pixels++;
    end
  endtask

  task automatic drain_pixels();
    int guard;
    guard = 0;
    while (pixel_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, reg_idx_e idx, logic [PDATA_BITS-1:0] wdata,
                            output logic [PDATA_BITS-1:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PADDR_BITS'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(reg_idx_e idx, logic [CFG_BITS-1:0] v);
    logic [PDATA_BITS-1:0] wd, rd;
    wd = $urandom();
    wd[CFG_BITS-1:0] = v;
    apb_access(1'b1, idx, wd, rd);
    if (idx == REG_WIDTH) scr_w = v;
    else scr_h = v;
    apb_access(1'b0, idx, $urandom(), rd);
    if (rd !== PDATA_BITS'(v))
      note_mismatch($sformatf("register %s read 0x%0h, want 0x%0h", idx.name(), rd, v));
  endtask

  task automatic draw_lines(int quota);
    coord_t sx, sy, ex, ey;
    int steps, lim, r, base;
    base = n_pixels;
    while (n_pixels - base < quota) begin
      if ($urandom_range(99) < 55) begin
        sx = near(scr_w);
        sy = near(scr_h);
      end else begin
        sx = coord_t'($urandom());
        sy = coord_t'($urandom());
      end
      r = $urandom_range(99);
      if (r < 90) begin
        ex = clampc(int'(sx) + int'($urandom_range(24)) - 12);
        ey = clampc(int'(sy) + int'($urandom_range(24)) - 12);
      end else if (r < 97) begin
        ex = clampc(int'(sx) + int'($urandom_range(600)) - 300);
        ey = clampc(int'(sy) + int'($urandom_range(600)) - 300);
      end else begin
        ex = coord_t'($urandom());
        ey = coord_t'($urandom());
      end
      offer(OP_LOAD, pack_line(sx, sy, ex, ey, COLOR_BITS'($urandom())), 1'b0, '0);
      steps = int'(ex) - int'(sx);
      if (steps < 0) steps = -steps;
      r = int'(ey) - int'(sy);
      if (r < 0) r = -r;
      if (r > steps) steps = r;
      lim = (steps > 80) ? 80 : steps;
      // cut short by the next load, or advanced past its end
      if ($urandom_range(99) < 8) lim = $urandom_range(lim);
      else if ($urandom_range(99) < 10) lim += $urandom_range(1, 3);
      repeat (lim)
        offer(OP_ADVANCE, IN_DATA_BITS'({$urandom(), $urandom(), $urandom()}), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.scr_x = m_axis_tdata[0 +: SCR_BITS];
      got.scr_y = m_axis_tdata[SCR_BITS +: SCR_BITS];
      got.addr = m_axis_tdata[2*SCR_BITS +: ADDR_BITS];
      got.color = m_axis_tdata[2*SCR_BITS+ADDR_BITS +: COLOR_BITS];
      got.off = m_axis_tuser;
      got.last = m_axis_tlast;
      if (pixel_q.size() == 0) begin
        note_mismatch({"unexpected pixel: ", fmt_pixel(got)});
      end else begin
        want = pixel_q.pop_front();
        if (got.scr_x !== want.scr_x || got.scr_y !== want.scr_y ||
            got.addr !== want.addr || got.color !== want.color ||
            got.off !== want.off || got.last !== want.last)
          note_mismatch({"pixel mismatch: want ", fmt_pixel(want), " got ", fmt_pixel(got)});
      end
    end
  end

  // output side: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    #3000000;
    $display("centered_line_rasterizer test failed");
    $finish;
  end

  initial begin
    int i;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIR; i++)
      offer(dir_tab[i].op,
            pack_line(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex, dir_tab[i].ey,
                      dir_tab[i].col),
            dir_tab[i].typed, dir_tab[i].want);
    draw_lines(PHASE_PIXELS / 2);
    drain_pixels();

    for (i = 0; i < N_PHASE; i++) begin
      set_reg(REG_WIDTH, (i == 7) ? CFG_BITS'($urandom_range(1, 4096)) : phase_w[i]);
      set_reg(REG_HEIGHT, (i == 7) ? CFG_BITS'($urandom_range(1, 4096)) : phase_h[i]);
      steady = (i == 4);
      if (i == 1) hold_req = 1'b1;
      draw_lines(PHASE_PIXELS);
      drain_pixels();
    end

    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("centered_line_rasterizer test passed");
    end else begin
      $display("centered_line_rasterizer test failed");
    end
    $finish;
  end

endmodule
